[hdl/fatlb_pkg.sv]
package fatlb_pkg;

   // default geometry
   localparam int ENTRIES_DEF     = 64;
   localparam int OFFSET_BITS_DEF = 12;
   localparam int TAG_BITS_DEF    = 20;

   // fixed field widths
   localparam int ADDR_W     = 32;
   localparam int PAGE_W     = 20;
   localparam int REQ_DATA_W = 56;   // 32 + 20 bits, padded to whole bytes
   localparam int RSP_DATA_W = 32;

   // victim LFSR (Galois, shift right)
   localparam int              LFSR_W    = 16;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
   localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

   typedef struct packed {
      logic load;        // capture request beat, restart scan
      logic scan;        // step the tag scan
      logic take_hit;    // latch page from matching entry
      logic take_miss;   // fill an entry with the walked page
      logic publish;     // move result into the output register
   } fatlb_cmd_type;

   typedef struct packed {
      logic match;         // entry under compare hits
      logic scan_end;      // all valid entries compared, no hit
      logic victim_ready;  // victim remainder settled
      logic out_free;      // output register can take a result
   } fatlb_status_type;

   function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
      return (s >> 1) ^ (s[0] ? LFSR_TAPS : '0);
   endfunction

endpackage

[hdl/fatlb_ctrl.sv]
module fatlb_ctrl
   import fatlb_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  fatlb_status_type status,
   output fatlb_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.match) begin
               cmd.take_hit = 1'b1;
               state_in     = ST_DONE;
            end else if (status.scan_end && status.victim_ready) begin
               cmd.take_miss = 1'b1;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hdl/fatlb_datapath.sv]
module fatlb_datapath
   import fatlb_pkg::*;
#(
   parameter int ENTRIES     = ENTRIES_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF,
   parameter int TAG_BITS    = TAG_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  fatlb_cmd_type         cmd,
   output fatlb_status_type      status
);

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int PA_W   = PAGE_W + OFFSET_BITS;

   // reciprocal of ENTRIES, exact for any 16-bit LFSR value
   localparam int RCP_SH  = LFSR_W + IDX_W;
   localparam int RCP_W   = LFSR_W + 2;
   localparam int MUL_W   = LFSR_W + RCP_W;
   localparam int BACK_W  = LFSR_W + CNT_W;
   localparam int RCP_INT = (1 << RCP_SH) / ENTRIES + 1;
   localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_INT);

   // request fields
   logic [ADDR_W-1:0]          req_addr;
   logic [PAGE_W-1:0]          req_walked;
   logic [ADDR_W+TAG_BITS-1:0] addr_ext;

   assign req_addr   = req_tdata[ADDR_W-1:0];
   assign req_walked = req_tdata[ADDR_W +: PAGE_W];
   assign addr_ext   = {{TAG_BITS{1'b0}}, req_addr};

   logic [TAG_BITS-1:0]    tag_ff;
   logic [OFFSET_BITS-1:0] offset_ff;
   logic [PAGE_W-1:0]      walked_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         tag_ff    <= addr_ext[OFFSET_BITS +: TAG_BITS];
         offset_ff <= req_addr[OFFSET_BITS-1:0];
         walked_ff <= req_walked;
      end
   end

   // entry stores; valid entries always form a prefix, so a fill count stands
   // in for the valid bits
   logic [TAG_BITS-1:0] tag_mem  [ENTRIES];
   logic [PAGE_W-1:0]   page_mem [ENTRIES];
   logic [TAG_BITS-1:0] tag_q_ff;
   logic [PAGE_W-1:0]   page_q_ff;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             chk_ff, chk_in;
   logic             in_range, full;
   logic [IDX_W-1:0] victim;

   assign in_range = rd_idx_ff < count_ff;
   assign full     = count_ff == CNT_W'(ENTRIES);

   always_ff @(posedge clock) begin
      if (cmd.take_miss) begin
         tag_mem[victim]  <= tag_ff;
         page_mem[victim] <= walked_ff;
      end
      tag_q_ff  <= tag_mem[rd_idx_ff[IDX_W-1:0]];
      page_q_ff <= page_mem[rd_idx_ff[IDX_W-1:0]];
   end

   always_comb begin
      rd_idx_in = rd_idx_ff;
      chk_in    = 1'b0;
      if (cmd.load) begin
         rd_idx_in = '0;
      end else if (cmd.scan) begin
         chk_in = in_range;
         if (in_range) begin
            rd_idx_in = rd_idx_ff + CNT_W'(1);
         end
      end
      count_in = count_ff;
      if (cmd.take_miss && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   assign status.match    = chk_ff && (tag_q_ff == tag_ff);
   assign status.scan_end = !chk_ff && !in_range;

   // victim LFSR and remainder by ENTRIES: quotient by reciprocal multiply in
   // the cycle after the load, remainder in the cycle after that
   logic [LFSR_W-1:0] lfsr_ff, lfsr_in;
   logic [LFSR_W-1:0] quo_ff, quo_in;
   logic [IDX_W-1:0]  rem_ff, rem_in;
   logic              quo_busy_ff, quo_busy_in;
   logic              rem_busy_ff, rem_busy_in;
   logic [MUL_W-1:0]  quo_prod;
   logic [BACK_W-1:0] back_prod, rem_diff;

   assign quo_prod  = MUL_W'(lfsr_ff) * MUL_W'(RCP);
   assign back_prod = BACK_W'(quo_ff) * BACK_W'(ENTRIES);
   assign rem_diff  = BACK_W'(lfsr_ff) - back_prod;

   always_comb begin
      lfsr_in     = lfsr_ff;
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      quo_busy_in = cmd.load;
      rem_busy_in = quo_busy_ff;
      if (cmd.load) begin
         lfsr_in = lfsr_step(lfsr_ff);
      end
      if (quo_busy_ff) begin
         quo_in = LFSR_W'(quo_prod >> RCP_SH);
      end
      if (rem_busy_ff) begin
         rem_in = rem_diff[IDX_W-1:0];
      end
   end

   assign status.victim_ready = !quo_busy_ff && !rem_busy_ff;
   assign victim = full ? rem_ff : count_ff[IDX_W-1:0];

   // result and output register
   logic [PAGE_W-1:0] res_page_ff;
   logic              res_hit_ff;
   logic [ADDR_W-1:0] out_pa_ff;
   logic              out_hit_ff;
   logic              out_valid_ff, out_valid_in;
   logic [PA_W-1:0]   pa_wide;

   assign pa_wide = {res_page_ff, offset_ff};

   always_ff @(posedge clock) begin
      if (cmd.take_hit) begin
         res_page_ff <= page_q_ff;
         res_hit_ff  <= 1'b1;
      end else if (cmd.take_miss) begin
         res_page_ff <= walked_ff;
         res_hit_ff  <= 1'b0;
      end
      if (cmd.publish) begin
         out_pa_ff  <= ADDR_W'(pa_wide);
         out_hit_ff <= res_hit_ff;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.publish) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign status.out_free = !out_valid_ff || rsp_tready;
   assign rsp_tvalid      = out_valid_ff;
   assign rsp_tdata       = out_pa_ff;
   assign rsp_tuser       = out_hit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_idx_ff    <= '0;
         chk_ff       <= 1'b0;
         lfsr_ff      <= LFSR_SEED;
         quo_ff       <= '0;
         rem_ff       <= '0;
         quo_busy_ff  <= 1'b0;
         rem_busy_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_idx_ff    <= rd_idx_in;
         chk_ff       <= chk_in;
         lfsr_ff      <= lfsr_in;
         quo_ff       <= quo_in;
         rem_ff       <= rem_in;
         quo_busy_ff  <= quo_busy_in;
         rem_busy_ff  <= rem_busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

[hdl/fully_assoc_tlb_random_replace_unit.sv]
// Fully associative TLB with random replacement. Each request beat carries a
// linear address and the physical page a page walk would return for it; each
// response beat gives the translated physical address and, in tuser, a hit
// flag. Entries are looked up in index order, one per cycle, through the
// single read port of the tag/page store, so a hit on entry i is found only
// after entries 0 .. i-1 have been compared. A miss compares every filled
// entry and waits for the victim remainder (quotient step, then remainder
// step). A miss fills the lowest free entry, or once the buffer is full,
// the entry given by a 16-bit LFSR modulo ENTRIES; the LFSR steps once
// per accepted beat, hit or miss. Reset empties the buffer at once (fill
// count cleared, no sweep). A finished response sits in an output register
// while the next beat is being accepted and looked up.
module fully_assoc_tlb_random_replace_unit
   import fatlb_pkg::*;
#(
   parameter int ENTRIES     = ENTRIES_DEF,      // 2 .. 256
   parameter int OFFSET_BITS = OFFSET_BITS_DEF,  // 8 .. 16
   parameter int TAG_BITS    = TAG_BITS_DEF      // 16 .. 24
) (
   input  logic                  clock,
   input  logic                  reset,
   // request: [31:0] linear_address, [51:32] walked_page, [55:52] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // response: [31:0] physical_address
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // response: [0] hit
   output logic                  rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready
);

   fatlb_cmd_type    cmd;
   fatlb_status_type status;

   // sequencer: idle / scan / hand-off
   fatlb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // entry store, compare, victim pick and output register
   fatlb_datapath #(
      .ENTRIES     (ENTRIES),
      .OFFSET_BITS (OFFSET_BITS),
      .TAG_BITS    (TAG_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
